// File: rtl/core/rpn_stack_calculator_unit_defines.svh
// Assertion macros shared by the calculator's RTL modules.
// Depends on nothing; included by the files that carry assertions.
`ifndef RPN_STACK_CALCULATOR_UNIT_DEFINES_SVH
`define RPN_STACK_CALCULATOR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/rsc_pkg.sv
// Shared types and constants of the RPN stack calculator.
// Depends on nothing; imported by every module of the block.
package rsc_pkg;

    localparam int WORD_W  = 32;
    localparam int DEPTH_W = 5;
    localparam int CODE_W  = 3;
    localparam int STEP_W  = $clog2(WORD_W);

    typedef logic [CODE_W-1:0] t_code;

    // Command codes of an input item.
    localparam t_code CMD_PUSH = 3'd0;
    localparam t_code CMD_ADD  = 3'd1;
    localparam t_code CMD_SUB  = 3'd2;
    localparam t_code CMD_MUL  = 3'd3;
    localparam t_code CMD_DIV  = 3'd4;

    // Error codes of a result item.
    localparam t_code ERR_NONE    = 3'd0;
    localparam t_code ERR_TOKEN   = 3'd1;
    localparam t_code ERR_FULL    = 3'd2;
    localparam t_code ERR_EMPTY   = 3'd3;
    localparam t_code ERR_DIVZERO = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_FETCH,
        S_DIV_WAIT,
        S_COMMIT,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  capture;
        logic  push;
        logic  fail;
        t_code fail_code;
        logic  exec;
        logic  commit;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_push;
        logic is_op;
        logic is_div;
        logic full;
        logic empty;
        logic div_done;
    } t_ctrl_status;

endpackage

// File: rtl/core/rsc_divider.sv
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating to zero.
// Depends on rsc_pkg.
module rsc_divider (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [rsc_pkg::WORD_W-1:0] i_dividend,
    input  logic [rsc_pkg::WORD_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [rsc_pkg::WORD_W-1:0] o_quotient
);
    import rsc_pkg::*;

    logic              r_active;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [WORD_W-1:0] r_rem;
    logic [WORD_W-1:0] r_quo;
    logic [WORD_W-1:0] r_dvs;
    logic              r_neg;
    logic              r_zero;

    logic [WORD_W:0]   trial;
    logic [WORD_W:0]   diff;

    assign trial = {r_rem, r_quo[WORD_W-1]};
    assign diff  = trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_done   <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_active <= 1'b1;
                r_cnt    <= STEP_W'(WORD_W - 1);
            end else if (r_active) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_active <= 1'b0;
                    r_done   <= 1'b1;
                end
            end
        end
    end

    // Work on magnitudes; the sign is put back at the output.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quo  <= i_dividend[WORD_W-1] ? (WORD_W'(0) - i_dividend) : i_dividend;
            r_dvs  <= i_divisor[WORD_W-1] ? (WORD_W'(0) - i_divisor) : i_divisor;
            r_neg  <= i_dividend[WORD_W-1] ^ i_divisor[WORD_W-1];
            r_zero <= (i_divisor == '0);
        end else if (r_active) begin
            if (!diff[WORD_W]) begin
                r_rem <= diff[WORD_W-1:0];
                r_quo <= {r_quo[WORD_W-2:0], 1'b1};
            end else begin
                r_rem <= trial[WORD_W-1:0];
                r_quo <= {r_quo[WORD_W-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_zero ? '0 : (r_neg ? (WORD_W'(0) - r_quo) : r_quo);

endmodule

// File: rtl/core/rsc_datapath.sv
// Stack memory, top-of-stack and count registers, ALU and result registers.
// Depends on rsc_pkg, rsc_divider and the assertion macro header.
`include "rpn_stack_calculator_unit_defines.svh"

module rsc_datapath #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rsc_pkg::t_ctrl_cmd          i_cmd,
    output rsc_pkg::t_ctrl_status       o_status,
    input  logic [rsc_pkg::CODE_W-1:0]  i_command,
    input  logic signed [rsc_pkg::WORD_W-1:0] i_number,
    output logic                        o_ok,
    output logic [rsc_pkg::CODE_W-1:0]  o_error_code,
    output logic signed [rsc_pkg::WORD_W-1:0] o_top_value,
    output logic [rsc_pkg::DEPTH_W-1:0] o_depth
);
    import rsc_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    logic [WORD_W-1:0] mem [STACK_DEPTH];

    logic [CODE_W-1:0] r_cmd;
    logic [WORD_W-1:0] r_num;
    logic [CW-1:0]     r_count;
    logic [WORD_W-1:0] r_top;
    logic [WORD_W-1:0] r_rd_data;
    logic [WORD_W-1:0] r_res;
    logic              r_ok;
    logic [CODE_W-1:0] r_err;

    logic [CW-1:0]     below_cnt;
    logic [AW-1:0]     below_addr;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              wr_en;
    logic              one_word;
    logic [WORD_W-1:0] left;
    logic              div_done;
    logic [WORD_W-1:0] div_quo;

    assign below_cnt  = r_count - CW'(2);
    assign below_addr = below_cnt[AW-1:0];
    assign one_word   = (r_count == CW'(1));
    // With one word on the stack, the top word serves as both operands.
    assign left       = one_word ? r_top : r_rd_data;

    always_comb begin
        wr_en   = i_cmd.push | i_cmd.commit;
        wr_addr = i_cmd.push ? r_count[AW-1:0] : (one_word ? '0 : below_addr);
        wr_data = i_cmd.push ? r_num : r_res;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[below_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd <= i_command;
            r_num <= i_number;
        end
        if (i_cmd.exec) begin
            case (r_cmd)
                CMD_ADD: r_res <= left + r_top;
                CMD_SUB: r_res <= left - r_top;
                CMD_MUL: r_res <= left * r_top;
                default: r_res <= r_res;
            endcase
        end else if (div_done) begin
            r_res <= div_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_top   <= '0;
            r_ok    <= 1'b0;
            r_err   <= ERR_NONE;
        end else begin
            if (i_cmd.push) begin
                r_count <= r_count + CW'(1);
                r_top   <= r_num;
                r_ok    <= 1'b1;
                r_err   <= ERR_NONE;
            end else if (i_cmd.fail) begin
                r_ok  <= 1'b0;
                r_err <= i_cmd.fail_code;
            end else if (i_cmd.commit) begin
                r_count <= one_word ? CW'(1) : (r_count - CW'(1));
                r_top   <= r_res;
                r_ok    <= 1'b1;
                // Division by zero still succeeds, but is flagged as a warning.
                r_err   <= (r_cmd == CMD_DIV && r_top == '0) ? ERR_DIVZERO : ERR_NONE;
            end
        end
    end

    rsc_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.exec && r_cmd == CMD_DIV),
        .i_dividend (left),
        .i_divisor  (r_top),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_comb begin
        o_status.is_push  = (r_cmd == CMD_PUSH);
        o_status.is_op    = (r_cmd == CMD_ADD) || (r_cmd == CMD_SUB) ||
                            (r_cmd == CMD_MUL) || (r_cmd == CMD_DIV);
        o_status.is_div   = (r_cmd == CMD_DIV);
        o_status.full     = (r_count == CW'(STACK_DEPTH));
        o_status.empty    = (r_count == '0);
        o_status.div_done = div_done;
    end

    assign o_ok         = r_ok;
    assign o_error_code = r_err;
    assign o_top_value  = r_top;
    assign o_depth      = DEPTH_W'(r_count);

    `RSC_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(STACK_DEPTH), "stack count above depth")
    `RSC_ASSERT_NOW(a_ok_codes, i_clk, i_rst_n, r_ok, (r_err == ERR_NONE || r_err == ERR_DIVZERO), "successful item carries a failure code")
    `RSC_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, i_cmd.push, r_count == $past(r_count) + CW'(1), "push did not grow the stack")

endmodule

// File: rtl/core/rsc_controller.sv
// Controller state machine: sequences decode, operand fetch, execute and commit.
// Depends on rsc_pkg and the assertion macro header.
`include "rpn_stack_calculator_unit_defines.svh"

module rsc_controller (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    output logic                  o_done,
    input  rsc_pkg::t_ctrl_status i_status,
    output rsc_pkg::t_ctrl_cmd    o_cmd
);
    import rsc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_status.is_op && !i_status.empty) begin
                    n_state = S_FETCH;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_FETCH: begin
                n_state = i_status.is_div ? S_DIV_WAIT : S_COMMIT;
            end
            S_DIV_WAIT: begin
                if (i_status.div_done) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: n_state = S_DONE;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        o_done = 1'b0;
        o_cmd.fail_code = ERR_NONE;
        case (r_state)
            S_IDLE: begin
                o_busy        = 1'b0;
                o_cmd.capture = i_start;
            end
            S_DECODE: begin
                if (i_status.is_push) begin
                    if (i_status.full) begin
                        o_cmd.fail      = 1'b1;
                        o_cmd.fail_code = ERR_FULL;
                    end else begin
                        o_cmd.push = 1'b1;
                    end
                end else if (i_status.is_op) begin
                    if (i_status.empty) begin
                        o_cmd.fail      = 1'b1;
                        o_cmd.fail_code = ERR_EMPTY;
                    end
                end else begin
                    o_cmd.fail      = 1'b1;
                    o_cmd.fail_code = ERR_TOKEN;
                end
            end
            S_FETCH:    o_cmd.exec   = 1'b1;
            S_DIV_WAIT: o_cmd.exec   = 1'b0;
            S_COMMIT:   o_cmd.commit = 1'b1;
            S_DONE:     o_done       = 1'b1;
            default:    o_busy       = 1'b1;
        endcase
    end

    `RSC_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done, "result strobe longer than one cycle")
    `RSC_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy, "accepted item did not raise busy")
    `RSC_ASSERT_NEXT(a_div_wait, i_clk, i_rst_n, o_cmd.exec && i_status.is_div, r_state == S_DIV_WAIT, "divide did not wait for the divider")

endmodule

// File: rtl/core/rpn_stack_calculator_unit.sv
// Top level of the RPN stack calculator: controller plus datapath.
// Depends on rsc_pkg, rsc_controller and rsc_datapath.
//
//  Channel   Handshake             Ports
//  -------   -------------------   ------------------------------------------
//  item in   start high, busy low  i_command, i_number
//  result    o_done strobe, 1 cyc  o_ok, o_error_code, o_top_value, o_depth
//
// A push, an unknown token or any failed item raises busy in decode and done,
// strobing its result in done. Add, subtract and multiply go through decode,
// fetch, commit and done; divide waits after fetch for the bit-serial divider
// that produces one quotient bit per cycle. A new item may be accepted in the
// cycle after the strobe. Reset is synchronous and active low; it empties the
// stack, while the stack memory itself keeps whatever it held. The receiver
// cannot stall, so every result is shown for exactly one cycle.
module rpn_stack_calculator_unit #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [rsc_pkg::CODE_W-1:0]        i_command,
    input  logic signed [rsc_pkg::WORD_W-1:0] i_number,
    output logic                              o_done,
    output logic                              o_ok,
    output logic [rsc_pkg::CODE_W-1:0]        o_error_code,
    output logic signed [rsc_pkg::WORD_W-1:0] o_top_value,
    output logic [rsc_pkg::DEPTH_W-1:0]       o_depth
);
    import rsc_pkg::*;

    // The controller only sees command class and stack status; all values
    // stay in the datapath.
    t_ctrl_cmd    ctrl_cmd;
    t_ctrl_status ctrl_status;

    rsc_controller u_controller (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .o_busy   (busy),
        .o_done   (o_done),
        .i_status (ctrl_status),
        .o_cmd    (ctrl_cmd)
    );

    // The datapath keeps the top word in a register, so the right operand is
    // always at hand and only the word below it is read from the memory.
    rsc_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (ctrl_cmd),
        .o_status     (ctrl_status),
        .i_command    (i_command),
        .i_number     (i_number),
        .o_ok         (o_ok),
        .o_error_code (o_error_code),
        .o_top_value  (o_top_value),
        .o_depth      (o_depth)
    );

endmodule
